// ===== hdl/id128dd_pkg.sv =====
package id128dd_pkg;

    localparam int CFG_W    = 4;
    localparam int MIN_LOG2 = 4;
    localparam int STATUS_W = 2;
    localparam int PROBE_W  = 10;
    localparam int ID_W     = 64;

    localparam logic [CFG_W-1:0] CFG_LOG2_RESET = 4'd9;

    localparam logic ACT_CLEAR  = 1'b0;
    localparam logic ACT_INSERT = 1'b1;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NIL       = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic            action;
        logic [ID_W-1:0] id_high;
        logic [ID_W-1:0] id_low;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PROBE_W-1:0]  probe_count;
    } t_result;

endpackage

// ===== hdl/id128dd_ram.sv =====
module id128dd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/id128_duplicate_detector_top.sv =====
// Duplicate detector for 128-bit ids: an open-addressing hash set with linear
// probing from the home bucket (low bits of id_low) over 2**table_size_log2
// slots, clamped to 16..TABLE_SLOTS. Every start beat gives exactly one result
// beat on o_valid, which cannot be stalled and must be taken when shown.
// Operation: after reset and after each clear beat the slot memory is swept, one
// slot a cycle, with busy high (the clear result is given at once). A nil id
// is answered without a table lookup. An insert reads the slot memory once per
// probe, and each probed slot that points at a stored id costs one more read
// of the id memory for the compare. The result is registered from the last
// probe decision, which is taken on the registered memory read data; busy
// drops together with that result.
module id128_duplicate_detector_top #(
    parameter int MAX_IDS     = 256,
    parameter int TABLE_SLOTS = 512
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  id128dd_pkg::t_in_item        i_item,
    output logic                         o_valid,
    output id128dd_pkg::t_result         o_result,
    input  logic                         i_cfg_we,
    input  logic [id128dd_pkg::CFG_W-1:0] i_cfg_wdata
);
    import id128dd_pkg::*;

    localparam int IDX_W = $clog2(TABLE_SLOTS);
    localparam int CNT_W = IDX_W + 1;
    localparam int ENT_W = $clog2(MAX_IDS + 1);
    localparam int IDA_W = $clog2(MAX_IDS);
    localparam int EFF_W = $clog2(IDX_W + 1);
    localparam int KEY_W = 2 * ID_W;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SLOT,
        S_ID
    } t_state;

    t_state              r_state, n_state;
    logic [IDX_W-1:0]    r_clr_addr, n_clr_addr;
    logic [ENT_W-1:0]    r_count, n_count;
    logic [CFG_W-1:0]    r_log2;
    logic                r_valid, n_valid;
    t_result             r_result, n_result;
    logic [ID_W-1:0]     r_hi, n_hi;
    logic [ID_W-1:0]     r_lo, n_lo;
    logic [IDX_W-1:0]    r_bucket, n_bucket;
    logic [CNT_W-1:0]    r_probes, n_probes;

    logic [EFF_W-1:0]    w_eff;
    logic [CNT_W-1:0]    w_cap;
    logic [IDX_W-1:0]    w_mask;
    logic [CNT_W-1:0]    w_probe1;

    logic                slot_we;
    logic [IDX_W-1:0]    slot_waddr;
    logic [ENT_W-1:0]    slot_wdata;
    logic [ENT_W-1:0]    slot_rdata;
    logic [ENT_W-1:0]    w_idx;
    logic                w_live;
    logic                id_we;
    logic [KEY_W-1:0]    id_rdata;

    // log2 of the effective table size
    always_comb begin
        if (int'(r_log2) < MIN_LOG2) begin
            w_eff = EFF_W'(MIN_LOG2);
        end else if (int'(r_log2) > IDX_W) begin
            w_eff = EFF_W'(IDX_W);
        end else begin
            w_eff = EFF_W'(r_log2);
        end
    end

    assign w_cap    = CNT_W'(1) << w_eff;
    assign w_mask   = IDX_W'(w_cap - CNT_W'(1));
    assign w_probe1 = r_probes + CNT_W'(1);
    assign w_idx    = slot_rdata - ENT_W'(1);
    assign w_live   = (slot_rdata != '0) && (w_idx < r_count);

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_count    = r_count;
        n_valid    = 1'b0;
        n_result   = r_result;
        n_hi       = r_hi;
        n_lo       = r_lo;
        n_bucket   = r_bucket;
        n_probes   = r_probes;
        slot_we    = 1'b0;
        slot_waddr = r_bucket;
        slot_wdata = '0;
        id_we      = 1'b0;

        case (r_state)
            S_CLEAR: begin
                slot_we    = 1'b1;
                slot_waddr = r_clr_addr;
                n_clr_addr = r_clr_addr + IDX_W'(1);
                if (r_clr_addr == IDX_W'(TABLE_SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_hi = i_item.id_high;
                    n_lo = i_item.id_low;
                    if (i_item.action == ACT_CLEAR) begin
                        n_count    = '0;
                        n_clr_addr = '0;
                        n_state    = S_CLEAR;
                        n_valid    = 1'b1;
                        n_result   = '{status: ST_INSERTED, probe_count: '0};
                    end else if (i_item.id_high == '0 && i_item.id_low == '0) begin
                        n_valid  = 1'b1;
                        n_result = '{status: ST_NIL, probe_count: '0};
                    end else begin
                        n_bucket = i_item.id_low[IDX_W-1:0] & w_mask;
                        n_probes = '0;
                        n_state  = S_SLOT;
                    end
                end
            end
            S_SLOT: begin
                if (slot_rdata == '0) begin
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                    if (r_count == ENT_W'(MAX_IDS)) begin
                        n_result = '{status: ST_FULL, probe_count: PROBE_W'(w_probe1)};
                    end else begin
                        id_we      = 1'b1;
                        slot_we    = 1'b1;
                        slot_wdata = r_count + ENT_W'(1);
                        n_count    = r_count + ENT_W'(1);
                        n_result   = '{status: ST_INSERTED,
                                       probe_count: PROBE_W'(w_probe1)};
                    end
                end else if (w_live) begin
                    n_state = S_ID;
                end else if (w_probe1 == w_cap) begin
                    n_valid  = 1'b1;
                    n_state  = S_IDLE;
                    n_result = '{status: ST_FULL, probe_count: PROBE_W'(w_probe1)};
                end else begin
                    n_probes = w_probe1;
                    n_bucket = (r_bucket + IDX_W'(1)) & w_mask;
                end
            end
            S_ID: begin
                if (id_rdata == {r_hi, r_lo}) begin
                    n_valid  = 1'b1;
                    n_state  = S_IDLE;
                    n_result = '{status: ST_DUPLICATE, probe_count: PROBE_W'(w_probe1)};
                end else if (w_probe1 == w_cap) begin
                    n_valid  = 1'b1;
                    n_state  = S_IDLE;
                    n_result = '{status: ST_FULL, probe_count: PROBE_W'(w_probe1)};
                end else begin
                    n_probes = w_probe1;
                    n_bucket = (r_bucket + IDX_W'(1)) & w_mask;
                    n_state  = S_SLOT;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_count    <= '0;
            r_valid    <= 1'b0;
            r_log2     <= CFG_LOG2_RESET;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_count    <= n_count;
            r_valid    <= n_valid;
            if (i_cfg_we) begin
                r_log2 <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
        r_hi     <= n_hi;
        r_lo     <= n_lo;
        r_bucket <= n_bucket;
        r_probes <= n_probes;
    end

    // slot memory: 0 empty, k points at stored id k-1
    id128dd_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TABLE_SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_waddr),
        .i_wdata (slot_wdata),
        .i_raddr (n_bucket),
        .o_rdata (slot_rdata)
    );

    id128dd_ram #(
        .WIDTH (KEY_W),
        .DEPTH (MAX_IDS)
    ) u_id_ram (
        .i_clk   (i_clk),
        .i_we    (id_we),
        .i_waddr (r_count[IDA_W-1:0]),
        .i_wdata ({r_hi, r_lo}),
        .i_raddr (w_idx[IDA_W-1:0]),
        .o_rdata (id_rdata)
    );

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_result;
endmodule

// ===== sim/id128_duplicate_detector_top_tb.sv =====
`timescale 1ns / 100ps

module id128_duplicate_detector_top_tb;
    import id128dd_pkg::*;

    localparam int MAX_IDS     = 256;
    localparam int TABLE_SLOTS = 512;
    localparam int SLOT_LOG2   = $clog2(TABLE_SLOTS);
    localparam int WATCHDOG    = 8000;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    t_in_item          i_item = '0;
    logic              o_valid;
    t_result           o_result;
    logic              i_cfg_we = 1'b0;
    logic [CFG_W-1:0]  i_cfg_wdata = '0;

    id128_duplicate_detector_top #(
        .MAX_IDS    (MAX_IDS),
        .TABLE_SLOTS(TABLE_SLOTS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_valid    (o_valid),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always #10 i_clk = ~i_clk;

    // shadow copy of the hash set
    logic [CFG_W-1:0] size_log2;
    logic [8:0]       slot_map [TABLE_SLOTS];
    logic [ID_W-1:0]  id_hi_mem [MAX_IDS];
    logic [ID_W-1:0]  id_lo_mem [MAX_IDS];
    int               id_count;

    t_in_item         id_beats_pending [$];
    t_result          status_due [$];
    logic [127:0]     known_ids [$];

    int               mismatch_cnt = 0;
    int               idle_cycles = 0;
    bit               beat_taken = 1'b0;
    int               burst_left = 4;
    int               gap_left = 0;

    function automatic t_result dedup_lookup(t_in_item it);
        t_result r;
        int      eff_log2;
        int      cap;
        int      bkt;
        int      s;
        int      p;
        r = '0;
        if (it.action == ACT_CLEAR) begin
            foreach (slot_map[k]) slot_map[k] = '0;
            id_count = 0;
            r.status = ST_INSERTED;
            return r;
        end
        if (it.id_high == '0 && it.id_low == '0) begin
            r.status = ST_NIL;
            return r;
        end
        eff_log2 = (size_log2 < MIN_LOG2) ? MIN_LOG2 :
                   (size_log2 > SLOT_LOG2) ? SLOT_LOG2 : int'(size_log2);
        cap = 1 << eff_log2;
        bkt = int'(it.id_low[SLOT_LOG2-1:0]) & (cap - 1);
        for (p = 0; p < cap; p++) begin
            s = int'(slot_map[bkt]);
            if (s == 0) begin
                r.probe_count = PROBE_W'(p + 1);
                if (id_count >= MAX_IDS) begin
                    r.status = ST_FULL;
                end else begin
                    id_hi_mem[id_count] = it.id_high;
                    id_lo_mem[id_count] = it.id_low;
                    id_count++;
                    slot_map[bkt] = 9'(id_count);
                    r.status = ST_INSERTED;
                end
                return r;
            end
            if (s - 1 < id_count && id_hi_mem[s-1] == it.id_high &&
                id_lo_mem[s-1] == it.id_low) begin
                r.status = ST_DUPLICATE;
                r.probe_count = PROBE_W'(p + 1);
                return r;
            end
            bkt = (bkt + 1) & (cap - 1);
        end
        r.status = ST_FULL;
        r.probe_count = PROBE_W'(cap);
        return r;
    endfunction

    // input beats, shadow update, result check, watchdog
    always @(posedge i_clk) begin : monitor
        t_result want;
        beat_taken = 1'b0;
        if (!i_rst_n) begin
            size_log2 = CFG_LOG2_RESET;
            foreach (slot_map[k]) slot_map[k] = '0;
            id_count = 0;
        end else begin
            if (i_cfg_we)
                size_log2 = i_cfg_wdata;
            if (start && !busy) begin
                beat_taken = 1'b1;
                status_due.push_back(dedup_lookup(i_item));
                void'(id_beats_pending.pop_front());
            end
            if (o_valid) begin
                if (status_due.size() == 0) begin
                    $error("result beat with nothing pending: status=%0d probe_count=%0d",
                           o_result.status, o_result.probe_count);
                    mismatch_cnt++;
                end else begin
                    want = status_due.pop_front();
                    if (o_result.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_result.status);
                        mismatch_cnt++;
                    end
                    if (o_result.probe_count !== want.probe_count) begin
                        $error("probe_count: expected %0d, got %0d",
                               want.probe_count, o_result.probe_count);
                        mismatch_cnt++;
                    end
                end
            end
        end
        if (beat_taken || o_valid)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // sender: bursts of beats with random gaps
    always @(negedge i_clk) begin : driver
        if (beat_taken) begin
            if (burst_left > 0)
                burst_left--;
            if (burst_left == 0) begin
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                burst_left = $urandom_range(1, 16);
            end
        end
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (gap_left > 0) begin
            start <= 1'b0;
            gap_left--;
        end else if (id_beats_pending.size() != 0) begin
            start <= 1'b1;
            i_item <= id_beats_pending[0];
        end else begin
            start <= 1'b0;
        end
    end

    function automatic logic [127:0] fresh_id(bit clustered);
        logic [ID_W-1:0] hi;
        logic [ID_W-1:0] lo;
        hi = {$urandom, $urandom};
        lo = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: hi = '0;
            1: lo = '0;
            2: hi = '1;
            default: ;
        endcase
        if (clustered && $urandom_range(0, 2) == 0)
            lo[8:0] = 9'($urandom_range(0, 3));
        if (hi == '0 && lo == '0)
            lo[0] = 1'b1;
        return {hi, lo};
    endfunction

    task automatic queue_insert(logic [ID_W-1:0] hi, logic [ID_W-1:0] lo);
        t_in_item it;
        it.action = ACT_INSERT;
        it.id_high = hi;
        it.id_low = lo;
        id_beats_pending.push_back(it);
        if (hi != '0 || lo != '0)
            known_ids.push_back({hi, lo});
    endtask

    task automatic queue_clear();
        t_in_item it;
        it.action = ACT_CLEAR;
        it.id_high = {$urandom, $urandom};
        it.id_low = {$urandom, $urandom};
        id_beats_pending.push_back(it);
        known_ids.delete();
    endtask

    task automatic queue_mix(int n);
        logic [127:0] id;
        int           pick;
        repeat (n) begin
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
                queue_clear();
            end else if (pick < 11) begin
                queue_insert('0, '0);
            end else begin
                if (pick < 40 && known_ids.size() != 0)
                    id = known_ids[$urandom_range(0, known_ids.size() - 1)];
                else
                    id = fresh_id(1'b1);
                queue_insert(id[127:64], id[63:0]);
            end
        end
    endtask

    task automatic drain();
        do @(negedge i_clk);
        while (id_beats_pending.size() != 0 || status_due.size() != 0 || busy);
    endtask

    task automatic write_size(logic [CFG_W-1:0] v);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin : stimulus
        logic [CFG_W-1:0] phase_cfg [7];
        logic [127:0]     id;
        logic [127:0]     last_id;
        int               ph;
        phase_cfg = '{4'd15, 4'd4, 4'd7, 4'd3, 4'd5, 4'd6, 4'd8};

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        drain();

        // 16 slots: fill the table through one bucket cluster
        write_size('0);
        queue_insert('0, '0);
        queue_insert('0, 64'd1);
        queue_insert('1, '0);
        queue_insert('1, '1);
        queue_insert('1, '1);
        queue_insert('0, 64'd1);
        repeat (13) begin
            last_id = {{$urandom, $urandom}, {$urandom, $urandom}};
            last_id[3:0] = 4'h5;
            queue_insert(last_id[127:64], last_id[63:0]);
        end
        id = fresh_id(1'b0);
        queue_insert(id[127:64], id[63:0]);
        queue_insert(last_id[127:64], last_id[63:0]);
        queue_clear();
        queue_insert('1, '1);
        drain();

        // size changes with and without held ids
        for (ph = 0; ph < 7; ph++) begin
            write_size(phase_cfg[ph]);
            if (ph % 2 == 1)
                queue_clear();
            queue_mix(22);
            drain();
        end

        // 512 slots: id storage runs out before the table fills
        write_size(4'd9);
        queue_clear();
        for (int n = 0; n < 265; n++) begin
            id = fresh_id(1'b0);
            queue_insert(id[127:64], id[63:0]);
            if (n == 130)
                drain();
        end
        repeat (10) begin
            id = known_ids[$urandom_range(0, known_ids.size() - 1)];
            queue_insert(id[127:64], id[63:0]);
        end
        drain();

        repeat (TABLE_SLOTS + 32) @(posedge i_clk);
        if (mismatch_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
